### hw/rtl/fixed_point_alu_q24_8_top_assert.svh
// Assertion macros for the fixed-point ALU checker.
`ifndef FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_Q24_8_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define FXALU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("fxalu check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define FXALU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("fxalu check failed");

`endif

### hw/rtl/fxalu_pkg.sv
`timescale 1ns / 1ps
package fxalu_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam logic [3:0] OP_ADD    = 4'd0;
    localparam logic [3:0] OP_SUB    = 4'd1;
    localparam logic [3:0] OP_MUL    = 4'd2;
    localparam logic [3:0] OP_DIV    = 4'd3;
    localparam logic [3:0] OP_GT     = 4'd4;
    localparam logic [3:0] OP_LT     = 4'd5;
    localparam logic [3:0] OP_GE     = 4'd6;
    localparam logic [3:0] OP_LE     = 4'd7;
    localparam logic [3:0] OP_EQ     = 4'd8;
    localparam logic [3:0] OP_NE     = 4'd9;
    localparam logic [3:0] OP_INC    = 4'd10;
    localparam logic [3:0] OP_DEC    = 4'd11;
    localparam logic [3:0] OP_MIN    = 4'd12;
    localparam logic [3:0] OP_MAX    = 4'd13;
    localparam logic [3:0] OP_TO_INT = 4'd14;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OVF = 2'd1;
    localparam logic [1:0] ST_DZ  = 2'd2;

    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

endpackage

### hw/rtl/fixed_point_alu_q24_8_top.sv
`timescale 1ns / 1ps
// Throughput: one item per cycle unless a stall on m_tready holds the pipeline;
// the restoring divider takes one quotient bit per stage.
// All operations share the same pipeline, so results leave in input order.
// A stall on m_tready freezes every stage; nothing is dropped or repeated.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
module fixed_point_alu_q24_8_top #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] operation, [35:4] a_raw, [67:36] b_raw, [71:68] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] result_raw, [32] compare_true, [34:33] status, [39:35] zero
    output logic [39:0] m_tdata
);

    // Numerator width of the divider: magnitude of a shifted up by the fraction bits
    localparam int NW  = 32 + FRAC_BITS;
    // Stage 0 decode, NW divide steps, one divide finish stage (the output register)
    localparam int NST = NW + 2;
    localparam logic [63:0] MUL_RND = (64'd1 << FRAC_BITS) >> 1;

    typedef struct packed {
        logic [3:0]    op;
        logic [31:0]   res;
        logic          cmp;
        logic [1:0]    st;
        logic          neg;
        logic [31:0]   ma;
        logic [31:0]   mb;
        logic [NW-1:0] nsh;
        logic [31:0]   rem;
        logic [NW-1:0] quo;
        logic [63:0]   prod;
    } stage_t;

    stage_t           st_reg  [NST];
    stage_t           st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic             ce;

    logic [3:0]        in_op;
    logic signed [31:0] in_a;
    logic signed [31:0] in_b;
    logic [32:0]       sum_add, sum_sub, sum_inc, sum_dec;

    // Advance the whole pipeline when the output is empty or being taken
    assign ce       = !vld_reg[NST-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = {5'd0, st_reg[NST-1].st, st_reg[NST-1].cmp, st_reg[NST-1].res};

    assign in_op = s_tdata[3:0];
    assign in_a  = s_tdata[35:4];
    assign in_b  = s_tdata[67:36];

    assign sum_add = {in_a[31], in_a} + {in_b[31], in_b};
    assign sum_sub = {in_a[31], in_a} - {in_b[31], in_b};
    assign sum_inc = {in_a[31], in_a} + 33'd1;
    assign sum_dec = {in_a[31], in_a} - 33'd1;

    // Stage 0: decode, simple operations, operand magnitudes
    always_comb begin
        stage_t n;
        logic [31:0] ti;
        n      = '0;
        n.op   = in_op;
        n.neg  = in_a[31] ^ in_b[31];
        n.ma   = in_a[31] ? (32'd0 - in_a) : in_a;
        n.mb   = in_b[31] ? (32'd0 - in_b) : in_b;
        n.nsh  = NW'(n.ma) << FRAC_BITS;
        n.res  = '0;
        n.cmp  = 1'b0;
        n.st   = fxalu_pkg::ST_OK;
        ti     = n.ma >> FRAC_BITS;
        unique case (in_op)
            fxalu_pkg::OP_ADD: begin
                n.res = sum_add[31:0];
                if (sum_add[32] != sum_add[31]) begin
                    n.res = sum_add[32] ? fxalu_pkg::SAT_MIN : fxalu_pkg::SAT_MAX;
                    n.st  = fxalu_pkg::ST_OVF;
                end
            end
            fxalu_pkg::OP_SUB: begin
                n.res = sum_sub[31:0];
                if (sum_sub[32] != sum_sub[31]) begin
                    n.res = sum_sub[32] ? fxalu_pkg::SAT_MIN : fxalu_pkg::SAT_MAX;
                    n.st  = fxalu_pkg::ST_OVF;
                end
            end
            fxalu_pkg::OP_INC: begin
                n.res = sum_inc[31:0];
                if (sum_inc[32] != sum_inc[31]) begin
                    n.res = fxalu_pkg::SAT_MAX;
                    n.st  = fxalu_pkg::ST_OVF;
                end
            end
            fxalu_pkg::OP_DEC: begin
                n.res = sum_dec[31:0];
                if (sum_dec[32] != sum_dec[31]) begin
                    n.res = fxalu_pkg::SAT_MIN;
                    n.st  = fxalu_pkg::ST_OVF;
                end
            end
            fxalu_pkg::OP_GT:  n.cmp = in_a >  in_b;
            fxalu_pkg::OP_LT:  n.cmp = in_a <  in_b;
            fxalu_pkg::OP_GE:  n.cmp = in_a >= in_b;
            fxalu_pkg::OP_LE:  n.cmp = in_a <= in_b;
            fxalu_pkg::OP_EQ:  n.cmp = in_a == in_b;
            fxalu_pkg::OP_NE:  n.cmp = in_a != in_b;
            fxalu_pkg::OP_MIN: n.res = (in_a < in_b) ? in_a : in_b;
            fxalu_pkg::OP_MAX: n.res = (in_a > in_b) ? in_a : in_b;
            fxalu_pkg::OP_TO_INT: n.res = in_a[31] ? (32'd0 - ti) : ti;
            default: ;
        endcase
        st_next[0] = n;
    end

    // Stages 1..NW: one restoring divide step each; stage 1 also multiplies,
    // stage 2 rounds and saturates the product, the last stage finishes divide
    for (genvar k = 1; k < NST; k++) begin : g_stage
        always_comb begin
            stage_t n;
            stage_t p;
            logic [32:0] t;
            logic        ge;
            logic [63:0] m;
            logic        up;
            p = st_reg[k-1];
            n = p;
            t  = '0;
            ge = 1'b0;
            m  = '0;
            up = 1'b0;
            if (k <= NW) begin
                t     = {p.rem, p.nsh[NW-1]};
                ge    = t >= {1'b0, p.mb};
                n.rem = ge ? 32'(t - {1'b0, p.mb}) : t[31:0];
                n.nsh = p.nsh << 1;
                n.quo = {p.quo[NW-2:0], ge};
            end
            if (k == 1) begin
                n.prod = 64'(p.ma) * 64'(p.mb);
            end
            if (k == 2 && p.op == fxalu_pkg::OP_MUL) begin
                m = (p.prod + MUL_RND) >> FRAC_BITS;
                if (p.neg) begin
                    if (m > 64'h8000_0000) begin
                        n.res = fxalu_pkg::SAT_MIN;
                        n.st  = fxalu_pkg::ST_OVF;
                    end else begin
                        n.res = 32'd0 - m[31:0];
                    end
                end else if (m > 64'h7FFF_FFFF) begin
                    n.res = fxalu_pkg::SAT_MAX;
                    n.st  = fxalu_pkg::ST_OVF;
                end else begin
                    n.res = m[31:0];
                end
            end
            if (k == NST - 1 && p.op == fxalu_pkg::OP_DIV) begin
                // Round half away from zero: bump when twice the remainder reaches the divisor
                up = {p.rem, 1'b0} >= {1'b0, p.mb};
                m  = 64'(p.quo) + 64'(up);
                if (p.mb == 32'd0) begin
                    n.res = '0;
                    n.st  = fxalu_pkg::ST_DZ;
                end else if (p.neg) begin
                    if (m > 64'h8000_0000) begin
                        n.res = fxalu_pkg::SAT_MIN;
                        n.st  = fxalu_pkg::ST_OVF;
                    end else begin
                        n.res = 32'd0 - m[31:0];
                    end
                end else if (m > 64'h7FFF_FFFF) begin
                    n.res = fxalu_pkg::SAT_MAX;
                    n.st  = fxalu_pkg::ST_OVF;
                end else begin
                    n.res = m[31:0];
                end
            end
            st_next[k] = n;
        end
    end

    // Valid bits travel with the data; hold everything while stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int i = 0; i < NST; i++) begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule

### hw/rtl/fxalu_checker.sv
`timescale 1ns / 1ps
`include "fixed_point_alu_q24_8_top_assert.svh"
module fxalu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result holds its payload
    `FXALU_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A true comparison carries a zero result and good status
    `FXALU_ASSERT_IMP(a_cmp, m_tvalid && m_tdata[32], m_tdata[31:0] == 32'd0 && m_tdata[34:33] == fxalu_pkg::ST_OK)

    // Divide by zero gives a zero result
    `FXALU_ASSERT_IMP(a_dz, m_tvalid && m_tdata[34:33] == fxalu_pkg::ST_DZ, m_tdata[31:0] == 32'd0 && !m_tdata[32])

    // Saturation only to the range ends
    `FXALU_ASSERT_IMP(a_ovf, m_tvalid && m_tdata[34:33] == fxalu_pkg::ST_OVF, m_tdata[31:0] == fxalu_pkg::SAT_MAX || m_tdata[31:0] == fxalu_pkg::SAT_MIN)

endmodule

bind fixed_point_alu_q24_8_top fxalu_checker u_fxalu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
